>>> hdl/pbis_pkg.sv
// Package for the particle box integrate step unit.
// Holds the item structs, word widths and register indexes; no dependencies.
package pbis_pkg;
  localparam int WordBits = 24;
  localparam int FracBits = 20;
  localparam int RegBits  = 1;
  localparam logic [RegBits-1:0] RegGravity  = 1'd0;
  localparam logic [RegBits-1:0] RegTimeStep = 1'd1;

  typedef struct packed {
    logic signed [WordBits-1:0] pos_x;
    logic signed [WordBits-1:0] pos_y;
    logic signed [WordBits-1:0] vel_x;
    logic signed [WordBits-1:0] vel_y;
    logic        [FracBits:0]   radius;
    logic        [WordBits-2:0] max_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [WordBits-1:0] new_x;
    logic signed [WordBits-1:0] new_y;
    logic signed [WordBits-1:0] new_vx;
    logic signed [WordBits-1:0] new_vy;
    logic                       speed_clamped;
  } out_item_t;
endpackage

>>> hdl/particle_box_integrate_step_unit.sv
// Top level of the particle box integrate step unit.
// Depends on pbis_pkg, pbis_sqrt, pbis_div and pbis_delay.
//
// One Euler step per particle with terminal-speed clamp and wall reflection.
// Accepts one item every cycle (start while busy is low; busy is always low)
// and presents its result on result_o, with done_o high for one cycle.
// The 78 stages are 4 front stages (gravity and x products, velocity and x
// sums, y product and squares, y sum and clamp test), 24 square-root stages,
// 1 numerator stage, 46 divider stages and 3 back stages (scaling, horizontal
// walls, vertical walls into the output register). The pipeline length is set
// by the one-bit-per-stage root and divide. The receiver cannot stall, so
// nothing holds results back.
// Write gravity and time_step only while no item is in flight.
module particle_box_integrate_step_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pbis_pkg::in_item_t  item_i,
  output logic                done_o,
  output pbis_pkg::out_item_t result_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i
);
  import pbis_pkg::*;
  localparam int W  = WordBits;
  localparam int F  = FracBits;
  localparam int SqrtIn = 2 * W;
  localparam int Nq = 2 * W - 2;
  localparam int Lat = 4 + W + 1 + Nq + 3;
  localparam logic signed [W+2:0] One = (W+3)'(1) <<< F;
  localparam logic signed [W-1:0] Hi = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] Lo = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] grav_q;
  logic        [W-2:0] ts_q;
  logic [Lat-1:0]      vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= W'(-10486);
      ts_q   <= (W-1)'(1 << F);
      vld_q  <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
      if (cfg_we_i && cfg_idx_i == RegGravity)  grav_q <= cfg_data_i[W-1:0];
      if (cfg_we_i && cfg_idx_i == RegTimeStep) ts_q   <= cfg_data_i[W-2:0];
    end
  end

  function automatic logic signed [W-1:0] sat_f(input logic signed [2*W+1:0] v);
    if (v > (2*W+2)'(Hi)) return Hi;
    if (v < (2*W+2)'(Lo)) return Lo;
    return v[W-1:0];
  endfunction

  // Stage 1: gravity and x product (floor shift = arithmetic shift)
  logic signed [2*W:0] gp, xp;
  in_item_t it1_q;
  logic signed [W-1:0] gt1_q, xd1_q;
  always_comb begin
    gp = $signed({{(W+1){grav_q[W-1]}}, grav_q}) * $signed({2'b0, ts_q});
    xp = $signed({{(W+1){item_i.vel_x[W-1]}}, item_i.vel_x}) * $signed({2'b0, ts_q});
  end
  always_ff @(posedge clk_i) begin
    it1_q <= item_i;
    gt1_q <= sat_f((2*W+2)'(gp >>> F));
    xd1_q <= sat_f((2*W+2)'(xp >>> F));
  end

  // Stage 2: new vy, new x
  logic signed [W-1:0] vy2_q, x2_q;
  in_item_t it2_q;
  always_ff @(posedge clk_i) begin
    it2_q <= it1_q;
    vy2_q <= sat_f((2*W+2)'(it1_q.vel_y) + (2*W+2)'(gt1_q));
    x2_q  <= sat_f((2*W+2)'(it1_q.pos_x) + (2*W+2)'(xd1_q));
  end

  // Stage 3: y product, squares
  logic signed [2*W:0] yp;
  logic [W-1:0] ax, ay;
  logic [SqrtIn-1:0] s2_3_q, vt2_3_q;
  logic signed [W-1:0] yd3_q, vy3_q, x3_q;
  in_item_t it3_q;
  always_comb begin
    yp = $signed({{(W+1){vy2_q[W-1]}}, vy2_q}) * $signed({2'b0, ts_q});
    ax = it2_q.vel_x[W-1] ? W'(-it2_q.vel_x) : it2_q.vel_x;
    ay = vy2_q[W-1] ? W'(-vy2_q) : vy2_q;
  end
  always_ff @(posedge clk_i) begin
    it3_q   <= it2_q;
    vy3_q   <= vy2_q;
    x3_q    <= x2_q;
    yd3_q   <= sat_f((2*W+2)'(yp >>> F));
    s2_3_q  <= SqrtIn'(ax) * SqrtIn'(ax) + SqrtIn'(ay) * SqrtIn'(ay);
    vt2_3_q <= SqrtIn'(it2_q.max_speed) * SqrtIn'(it2_q.max_speed);
  end

  // Stage 4: new y, clamp decision, enter root
  typedef struct packed {
    logic signed [W-1:0] x, y, vx, vy;
    logic [F:0] r;
    logic [W-2:0] vt;
    logic cl;
  } side_t;
  side_t s4_q, s_sq, s_dv;
  logic [SqrtIn-1:0] s2_4_q;
  always_ff @(posedge clk_i) begin
    s4_q.x  <= x3_q;
    s4_q.y  <= sat_f((2*W+2)'(it3_q.pos_y) + (2*W+2)'(yd3_q));
    s4_q.vx <= it3_q.vel_x;
    s4_q.vy <= vy3_q;
    s4_q.r  <= it3_q.radius;
    s4_q.vt <= it3_q.max_speed;
    s4_q.cl <= s2_3_q > vt2_3_q;
    s2_4_q  <= s2_3_q;
  end

  logic [W-1:0] sp;
  pbis_sqrt #(.InBits(SqrtIn)) u_sqrt (.clk_i, .rad_i(s2_4_q), .root_o(sp));
  pbis_delay #(.Width($bits(side_t)), .Depth(W)) u_dly_sq (
    .clk_i, .d_i(s4_q), .q_o(s_sq));

  // Stage after root: magnitude times terminal speed, two dividers
  logic [Nq-1:0] nx_q, ny_q, qx, qy;
  logic [W-1:0] den_q;
  side_t m_q;
  logic [W-1:0] mx, my;
  always_comb begin
    mx = s_sq.vx[W-1] ? W'(-s_sq.vx) : s_sq.vx;
    my = s_sq.vy[W-1] ? W'(-s_sq.vy) : s_sq.vy;
  end
  always_ff @(posedge clk_i) begin
    nx_q  <= Nq'(SqrtIn'(mx) * SqrtIn'(s_sq.vt));
    ny_q  <= Nq'(SqrtIn'(my) * SqrtIn'(s_sq.vt));
    den_q <= (sp == '0) ? W'(1) : sp;
    m_q   <= s_sq;
  end
  pbis_div #(.NumBits(Nq), .DenBits(W)) u_div_x (.clk_i, .num_i(nx_q), .den_i(den_q), .quo_o(qx));
  pbis_div #(.NumBits(Nq), .DenBits(W)) u_div_y (.clk_i, .num_i(ny_q), .den_i(den_q), .quo_o(qy));
  pbis_delay #(.Width($bits(side_t)), .Depth(Nq)) u_dly_dv (
    .clk_i, .d_i(m_q), .q_o(s_dv));

  // Apply scaling with sign and saturation
  side_t v_q, v_d;
  logic signed [2*W+1:0] sqx, sqy;
  always_comb begin
    sqx = s_dv.vx[W-1] ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
    sqy = s_dv.vy[W-1] ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
    v_d = s_dv;
    if (s_dv.cl) begin
      v_d.vx = sat_f(sqx);
      v_d.vy = sat_f(sqy);
    end
  end
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  // Walls: horizontal pair, then vertical pair
  function automatic logic signed [W-1:0] neg_f(input logic signed [W-1:0] v);
    return (v == Lo) ? Hi : W'(-v);
  endfunction
  side_t w_q, w_d;
  logic signed [W+2:0] lim, y1, yv;
  logic signed [W-1:0] vy1;
  always_comb begin
    lim = One - $signed({2'b0, v_q.r});
    yv  = $signed({{3{v_q.y[W-1]}}, v_q.y});
    vy1 = v_q.vy;
    y1  = yv;
    if (yv > lim) begin
      y1  = (W+3)'(sat_f((2*W+2)'(2*lim - yv)));
      vy1 = neg_f(vy1);
    end
    if (y1 < -lim) begin
      y1  = (W+3)'(sat_f((2*W+2)'(-2*lim - y1)));
      vy1 = neg_f(vy1);
    end
    w_d    = v_q;
    w_d.y  = y1[W-1:0];
    w_d.vy = vy1;
  end
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  logic signed [W+2:0] limx, x1, xv;
  logic signed [W-1:0] vx1;
  always_comb begin
    limx = One - $signed({2'b0, w_q.r});
    xv   = $signed({{3{w_q.x[W-1]}}, w_q.x});
    vx1  = w_q.vx;
    x1   = xv;
    if (xv > limx) begin
      x1  = (W+3)'(sat_f((2*W+2)'(2*limx - xv)));
      vx1 = neg_f(vx1);
    end
    if (x1 < -limx) begin
      x1  = (W+3)'(sat_f((2*W+2)'(-2*limx - x1)));
      vx1 = neg_f(vx1);
    end
  end
  always_ff @(posedge clk_i) begin
    result_o.new_x         <= x1[W-1:0];
    result_o.new_y         <= w_q.y;
    result_o.new_vx        <= vx1;
    result_o.new_vy        <= w_q.vy;
    result_o.speed_clamped <= w_q.cl;
  end
  assign done_o = vld_q[Lat-1];
endmodule

>>> hdl/pbis_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Uses no package.
module pbis_sqrt #(
  parameter int InBits = 48
) (
  input  logic                  clk_i,
  input  logic [InBits-1:0]     rad_i,
  output logic [InBits/2-1:0]   root_o
);
  localparam int N = InBits / 2;
  logic [InBits-1:0] rem_q  [N+1];
  logic [N-1:0]      root_q [N+1];

  assign rem_q[0]  = rad_i;
  assign root_q[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [InBits-1:0] trial;
    logic [InBits-1:0] rem_d;
    logic [N-1:0]      root_d;
    localparam int B = N - 1 - k;
    always_comb begin
      trial  = ({{(InBits-N){1'b0}}, root_q[k]} << (B + 1)) |
               ({{(InBits-1){1'b0}}, 1'b1} << (2*B));
      rem_d  = rem_q[k];
      root_d = root_q[k];
      if (rem_q[k] >= trial) begin
        rem_d  = rem_q[k] - trial;
        root_d[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= root_d;
    end
  end
  assign root_o = root_q[N];
endmodule

>>> hdl/pbis_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Uses no package.
module pbis_div #(
  parameter int NumBits = 46,
  parameter int DenBits = 24
) (
  input  logic               clk_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic [NumBits-1:0] quo_o
);
  logic [NumBits-1:0] num_q [NumBits+1];
  logic [DenBits:0]   rem_q [NumBits+1];
  logic [DenBits-1:0] den_q [NumBits+1];

  assign num_q[0] = num_i;
  assign rem_q[0] = '0;
  assign den_q[0] = den_i;

  for (genvar k = 0; k < NumBits; k++) begin : g_st
    logic [DenBits:0]   shl;
    logic [DenBits:0]   rem_d;
    logic [NumBits-1:0] num_d;
    always_comb begin
      shl   = {rem_q[k][DenBits-1:0], num_q[k][NumBits-1]};
      num_d = {num_q[k][NumBits-2:0], 1'b0};
      rem_d = shl;
      if (shl >= {1'b0, den_q[k]}) begin
        rem_d    = shl - {1'b0, den_q[k]};
        num_d[0] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[k+1] <= num_d;
      rem_q[k+1] <= rem_d;
      den_q[k+1] <= den_q[k];
    end
  end
  assign quo_o = num_q[NumBits];
endmodule

>>> hdl/pbis_delay.sv
// Fixed-length register delay line for side payload.
// Uses no package.
module pbis_delay #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);
  logic [Width-1:0] tap_q [Depth+1];
  assign tap_q[0] = d_i;
  for (genvar k = 0; k < Depth; k++) begin : g_tap
    always_ff @(posedge clk_i) tap_q[k+1] <= tap_q[k];
  end
  assign q_o = tap_q[Depth];
endmodule
